FILE: hdl/ssrg_pkg.sv
// Package for the sorted sample range grouper.
// Holds default sizes, the gap register format and the controller/datapath
// command and status structs. Depends on nothing.
package ssrg_pkg;

    localparam int SAMPLE_DEPTH_DEF = 32;
    localparam int SAMPLE_BITS_DEF  = 12;

    localparam int             GAP_BITS  = 12;
    localparam logic [11:0]    GAP_RESET = 12'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // word accepted on the sample channel
        logic ins_rd;      // read the store entry below the insert slot
        logic ins_shift;   // move that entry up one slot
        logic ins_put;     // write the new sample into the insert slot
        logic walk_rd;     // read the next sorted entry
        logic walk_first;  // open the first range with the entry read
        logic walk_merge;  // add the entry read to the open range
        logic walk_split;  // emit the open range, open a new one
        logic emit_final;  // emit the last range of the set
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic j_zero;
        logic rd_greater;
        logic full;
        logic last_flag;
        logic walk_done;
        logic walk_first;
        logic close;
        logic out_busy;
    } t_sts;

endpackage

FILE: hdl/ssrg_in_if.sv
// Sample channel of the sorted sample range grouper.
// Carries valid, ready and one sample word; no dependencies.
interface ssrg_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

FILE: hdl/ssrg_out_if.sv
// Range channel of the sorted sample range grouper.
// Carries valid, ready and one range word; no dependencies.
interface ssrg_out_if #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 6
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] range_low;
    logic [SAMPLE_BITS-1:0] range_high;
    logic [COUNT_BITS-1:0]  sample_count;
    logic                   last_range;
    logic                   samples_dropped;

    modport source (output valid, output range_low, output range_high,
                    output sample_count, output last_range,
                    output samples_dropped, input ready);
    modport sink   (input valid, input range_low, input range_high,
                    input sample_count, input last_range,
                    input samples_dropped, output ready);
endinterface

FILE: hdl/sorted_sample_range_grouper_top.sv
// Sorted sample range grouper: top level joining controller and datapath.
// Depends on ssrg_pkg, ssrg_in_if, ssrg_out_if, ssrg_ctrl and ssrg_datapath.
//
// Samples arrive one word at a time and are insertion-sorted into a single
// RAM as they come in: each stored sample larger than the new one is read,
// compared and moved up one slot before the new sample is written, paced by
// the read-compare-write loop on the store's one read port. A sample that
// finds the store full is dropped and flags the set. After the word marked
// last, the block walks the sorted store, closes the final range and emits
// one word per range, ascending, with the final one marked; the walk waits
// while a range word is held by the sink. The next set's first sample is
// taken as soon as the final range sits in the output register. The gap
// threshold is to be written by the user only at an idle time; the block
// itself does not enforce it. It resets to 2; there is no clearing pass
// after reset.
module sorted_sample_range_grouper_top #(
    parameter int SAMPLE_DEPTH = ssrg_pkg::SAMPLE_DEPTH_DEF,
    parameter int SAMPLE_BITS  = ssrg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ssrg_in_if.sink                       i_samples,
    ssrg_out_if.source                    o_ranges,
    input  logic                          i_cfg_wr_en,
    input  logic [ssrg_pkg::GAP_BITS-1:0] i_cfg_wr_data
);
    import ssrg_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ssrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_samples.valid),
        .o_in_ready (i_samples.ready),
        .i_in_last  (i_samples.last_sample),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ssrg_datapath #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_sample          (i_samples.sample),
        .i_last            (i_samples.last_sample),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .o_valid           (o_ranges.valid),
        .i_ready           (o_ranges.ready),
        .o_range_low       (o_ranges.range_low),
        .o_range_high      (o_ranges.range_high),
        .o_sample_count    (o_ranges.sample_count),
        .o_last_range      (o_ranges.last_range),
        .o_samples_dropped (o_ranges.samples_dropped)
    );
endmodule

FILE: hdl/ssrg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the sample store; no dependencies.
module ssrg_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/ssrg_datapath.sv
// Datapath of the sorted sample range grouper: sample store, insert pointer,
// fill count, range walk registers, gap register and the output register.
// Depends on ssrg_pkg and ssrg_ram.
module ssrg_datapath #(
    parameter int SAMPLE_DEPTH = 32,
    parameter int SAMPLE_BITS  = 12,
    localparam int AW = $clog2(SAMPLE_DEPTH),
    localparam int CW = $clog2(SAMPLE_DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ssrg_pkg::t_cmd               i_cmd,
    output ssrg_pkg::t_sts               o_sts,
    input  logic [SAMPLE_BITS-1:0]       i_sample,
    input  logic                         i_last,
    input  logic                         i_cfg_wr_en,
    input  logic [ssrg_pkg::GAP_BITS-1:0] i_cfg_wr_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [SAMPLE_BITS-1:0]       o_range_low,
    output logic [SAMPLE_BITS-1:0]       o_range_high,
    output logic [CW-1:0]                o_sample_count,
    output logic                         o_last_range,
    output logic                         o_samples_dropped
);
    import ssrg_pkg::*;

    localparam int GW = (SAMPLE_BITS > GAP_BITS) ? SAMPLE_BITS : GAP_BITS;

    logic [GAP_BITS-1:0]    r_gap;
    logic [CW-1:0]          r_fill;
    logic                   r_ovf;
    logic [CW-1:0]          r_idx;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_last;
    logic [AW-1:0]          r_j;
    logic [SAMPLE_BITS-1:0] r_lo;
    logic [SAMPLE_BITS-1:0] r_prev;
    logic [CW-1:0]          r_cnt;
    logic [SAMPLE_BITS-1:0] r_out_low;
    logic [SAMPLE_BITS-1:0] r_out_high;
    logic [CW-1:0]          r_out_cnt;
    logic                   r_out_last;
    logic                   r_out_drop;

    logic                   ram_we;
    logic                   ram_re;
    logic [AW-1:0]          ram_waddr;
    logic [AW-1:0]          ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic [SAMPLE_BITS-1:0] w_diff;
    logic                   w_emit;
    logic                   w_out_busy;

    assign ram_we    = i_cmd.ins_shift | i_cmd.ins_put;
    assign ram_waddr = r_j;
    assign ram_wdata = i_cmd.ins_shift ? ram_rdata : r_sample;
    assign ram_re    = i_cmd.ins_rd | i_cmd.walk_rd;
    assign ram_raddr = i_cmd.ins_rd ? (r_j - AW'(1)) : r_idx[AW-1:0];

    ssrg_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (SAMPLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The walk reads the store in ascending order, so the difference never wraps.
    assign w_diff     = ram_rdata - r_prev;
    assign w_emit     = i_cmd.walk_split | i_cmd.emit_final;
    assign w_out_busy = r_out_valid & ~i_ready;

    assign o_sts.j_zero     = (r_j == '0);
    assign o_sts.rd_greater = (ram_rdata > r_sample);
    assign o_sts.full       = (r_fill == CW'(SAMPLE_DEPTH));
    assign o_sts.last_flag  = r_last;
    assign o_sts.walk_done  = (r_idx == r_fill);
    assign o_sts.walk_first = (r_idx == '0);
    assign o_sts.close      = (GW'(w_diff) >= GW'(r_gap));
    assign o_sts.out_busy   = w_out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap       <= GAP_RESET;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_gap <= i_cfg_wr_data;
            end
            if (i_cmd.load && o_sts.full) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.ins_put) begin
                r_fill <= r_fill + CW'(1);
            end
            if (i_cmd.walk_first || i_cmd.walk_merge || i_cmd.walk_split) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.emit_final) begin
                r_fill <= '0;
                r_ovf  <= 1'b0;
                r_idx  <= '0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_last   <= i_last;
            r_j      <= r_fill[AW-1:0];
        end
        if (i_cmd.ins_shift) begin
            r_j <= r_j - AW'(1);
        end
        if (i_cmd.walk_first || i_cmd.walk_split) begin
            r_lo   <= ram_rdata;
            r_prev <= ram_rdata;
            r_cnt  <= CW'(1);
        end
        if (i_cmd.walk_merge) begin
            r_prev <= ram_rdata;
            r_cnt  <= r_cnt + CW'(1);
        end
        if (w_emit) begin
            r_out_low  <= r_lo;
            r_out_high <= r_prev;
            r_out_cnt  <= r_cnt;
            r_out_last <= i_cmd.emit_final;
            r_out_drop <= r_ovf;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_range_low       = r_out_low;
    assign o_range_high      = r_out_high;
    assign o_sample_count    = r_out_cnt;
    assign o_last_range      = r_out_last;
    assign o_samples_dropped = r_out_drop;
endmodule

FILE: hdl/ssrg_ctrl.sv
// Controller of the sorted sample range grouper: sequences loading with
// insertion into the store, the range walk and the final range.
// Depends on ssrg_pkg.
module ssrg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_in_last,
    input  ssrg_pkg::t_sts i_sts,
    output ssrg_pkg::t_cmd o_cmd
);
    import ssrg_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_INS_RD,
        S_INS_CMP,
        S_WALK_RD,
        S_WALK_CMP,
        S_FINAL
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_LOAD);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // A word that finds the store full is dropped, but it may still close the set.
                    if (!i_sts.full) begin
                        n_state = S_INS_RD;
                    end else if (i_in_last) begin
                        n_state = S_WALK_RD;
                    end
                end
            end
            S_INS_RD: begin
                if (i_sts.j_zero) begin
                    o_cmd.ins_put = 1'b1;
                    n_state = i_sts.last_flag ? S_WALK_RD : S_LOAD;
                end else begin
                    o_cmd.ins_rd = 1'b1;
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_sts.rd_greater) begin
                    o_cmd.ins_shift = 1'b1;
                    n_state = S_INS_RD;
                end else begin
                    o_cmd.ins_put = 1'b1;
                    n_state = i_sts.last_flag ? S_WALK_RD : S_LOAD;
                end
            end
            S_WALK_RD: begin
                if (i_sts.walk_done) begin
                    n_state = S_FINAL;
                end else begin
                    o_cmd.walk_rd = 1'b1;
                    n_state = S_WALK_CMP;
                end
            end
            S_WALK_CMP: begin
                if (i_sts.walk_first) begin
                    o_cmd.walk_first = 1'b1;
                    n_state = S_WALK_RD;
                end else if (!i_sts.close) begin
                    o_cmd.walk_merge = 1'b1;
                    n_state = S_WALK_RD;
                end else if (!i_sts.out_busy) begin
                    o_cmd.walk_split = 1'b1;
                    n_state = S_WALK_RD;
                end
            end
            S_FINAL: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit_final = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

FILE: hdl/ssrg_checker.sv
// Port-level checker for the sorted sample range grouper, with its bind.
// Depends on sorted_sample_range_grouper_top.
module ssrg_checker #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 6
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_in_last,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_range_low,
    input logic [SAMPLE_BITS-1:0] i_range_high,
    input logic [COUNT_BITS-1:0]  i_sample_count,
    input logic                   i_last_range,
    input logic                   i_samples_dropped
);
    // Set while a closed set still waits for its final range word.
    logic r_busy;
    logic n_busy;

    always_comb begin
        n_busy = r_busy;
        if (i_out_valid && i_last_range) begin
            n_busy = 1'b0;
        end
        if (i_in_valid && i_in_ready && i_in_last) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("range word valid right after reset");

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !(i_out_valid && i_last_range)) |-> !(i_in_valid && i_in_ready))
        else $error("sample word accepted before the set's final range");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_sample_count != '0))
        else $error("range word with zero samples");

    a_low_not_above_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_range_low <= i_range_high))
        else $error("range low above range high");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_range_low)
            && $stable(i_range_high) && $stable(i_sample_count)
            && $stable(i_last_range) && $stable(i_samples_dropped)))
        else $error("stalled range word changed");
endmodule

bind sorted_sample_range_grouper_top ssrg_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  ($clog2(SAMPLE_DEPTH + 1))
) u_ssrg_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_samples.valid),
    .i_in_ready        (i_samples.ready),
    .i_in_last         (i_samples.last_sample),
    .i_out_valid       (o_ranges.valid),
    .i_out_ready       (o_ranges.ready),
    .i_range_low       (o_ranges.range_low),
    .i_range_high      (o_ranges.range_high),
    .i_sample_count    (o_ranges.sample_count),
    .i_last_range      (o_ranges.last_range),
    .i_samples_dropped (o_ranges.samples_dropped)
);

FILE: sim/sorted_sample_range_grouper_top_test.sv
`timescale 1ns / 100ps
// Testbench for sorted_sample_range_grouper_top: runs a short table of sample sets and then
// random sets against a predictor of the range grouping, with random stalls on both channels.
// Depends on ssrg_pkg, ssrg_in_if, ssrg_out_if and the grouper RTL.
module sorted_sample_range_grouper_top_test;

    localparam int DEPTH       = ssrg_pkg::SAMPLE_DEPTH_DEF;
    localparam int BITS        = ssrg_pkg::SAMPLE_BITS_DEF;
    localparam int MAX_VAL     = (1 << BITS) - 1;
    localparam int SETTLE      = 2 * DEPTH + 8;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 350;

    typedef logic [BITS-1:0]              sample_t;
    typedef logic [ssrg_pkg::GAP_BITS-1:0] gap_t;

    typedef struct packed {
        sample_t    lo;
        sample_t    hi;
        logic [5:0] count;
        logic       fin;
        logic       dropped;
    } range_word_t;

    typedef enum logic {ROW_SAMPLE, ROW_GAP} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        sample_t     value;
        logic        fin;
        logic        typed;
        range_word_t want;
    } script_row_t;

    localparam int SCRIPT_ROWS = 24;

    // Typed expectations only for sets that form a single range.
    script_row_t script [SCRIPT_ROWS] = '{
        '{ROW_SAMPLE, 12'd0,    1'b1, 1'b1, '{12'd0,    12'd0,    6'd1, 1'b1, 1'b0}},
        '{ROW_SAMPLE, 12'd4095, 1'b1, 1'b1, '{12'd4095, 12'd4095, 6'd1, 1'b1, 1'b0}},
        '{ROW_SAMPLE, 12'd5,    1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 12'd5,    1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 12'd5,    1'b1, 1'b1, '{12'd5,    12'd5,    6'd3, 1'b1, 1'b0}},
        '{ROW_SAMPLE, 12'd10,   1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 12'd11,   1'b1, 1'b1, '{12'd10,   12'd11,   6'd2, 1'b1, 1'b0}},
        '{ROW_SAMPLE, 12'd20,   1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 12'd22,   1'b1, 1'b0, '0},
        '{ROW_SAMPLE, 12'd4095, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 12'd0,    1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 12'd2048, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 12'd4094, 1'b1, 1'b0, '0},
        '{ROW_GAP,    12'd4095, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 12'd0,    1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 12'd4094, 1'b1, 1'b1, '{12'd0,    12'd4094, 6'd2, 1'b1, 1'b0}},
        '{ROW_SAMPLE, 12'd4095, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 12'd0,    1'b1, 1'b0, '0},
        '{ROW_GAP,    12'd1,    1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 12'd7,    1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 12'd7,    1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 12'd8,    1'b1, 1'b0, '0},
        '{ROW_SAMPLE, 12'hAAA,  1'b0, 1'b0, '0},
        '{ROW_SAMPLE, 12'h555,  1'b1, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    gap_t i_cfg_wr_data;

    ssrg_in_if  #(.SAMPLE_BITS(BITS)) smp_if ();
    ssrg_out_if #(.SAMPLE_BITS(BITS)) rng_if ();

    sorted_sample_range_grouper_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_samples     (smp_if),
        .o_ranges      (rng_if),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Predictor state: the samples of the open set, its overflow flag and the gap register.
    sample_t     held_samples[$];
    bit          set_spilled;
    gap_t        gap_model;
    range_word_t pending_ranges[$];

    int  mismatches = 0;
    bit  in_steady;
    bit  out_steady = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Adds one accepted sample to the open set; on the last one, groups the sorted set.
    function automatic void absorb_sample(input sample_t s, input bit fin,
                                          ref range_word_t ranges[$]);
        int          n;
        int          first;
        bit          closes;
        range_word_t word;
        if (held_samples.size() < DEPTH)
            held_samples.push_back(s);
        else
            set_spilled = 1'b1;
        if (!fin)
            return;
        held_samples.sort();
        n = held_samples.size();
        first = 0;
        for (int i = 0; i < n; i++) begin
            closes = (i == n - 1) ||
                     (int'(held_samples[i+1]) - int'(held_samples[i]) >= int'(gap_model));
            if (closes) begin
                word.lo      = held_samples[first];
                word.hi      = held_samples[i];
                word.count   = 6'(i - first + 1);
                word.fin     = (i == n - 1);
                word.dropped = set_spilled;
                ranges.push_back(word);
                first = i + 1;
            end
        end
        held_samples.delete();
        set_spilled = 1'b0;
    endfunction

    task automatic send_sample(input sample_t s, input bit fin, input bit typed,
                               input range_word_t want);
        int          pause;
        range_word_t ranges[$];
        pause = in_steady ? 0 : $urandom_range(0, 6);
        if (pause > 0) begin
            smp_if.valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        smp_if.valid       <= 1'b1;
        smp_if.sample      <= s;
        smp_if.last_sample <= fin;
        do @(posedge i_clk); while (!smp_if.ready);
        absorb_sample(s, fin, ranges);
        if (typed)
            pending_ranges.push_back(want);
        else
            foreach (ranges[i]) pending_ranges.push_back(ranges[i]);
    endtask

    task automatic drain_ranges();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_ranges.size() != 0) @(posedge i_clk);
    endtask

    // The gap register is only written once the block has gone idle.
    task automatic set_gap(input gap_t value);
        drain_ranges();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        gap_model = value;
    endtask

    // Values are spread uniformly, clustered within twice the gap, placed on multiples of
    // the gap so that neighbours sit exactly at, just below or just above it, or drawn from a few repeats.
    task automatic send_random_set(input int count);
        int          shape;
        int          centre;
        int          x;
        sample_t     pool[3];
        range_word_t none;
        none  = '0;
        shape = $urandom_range(0, 3);
        centre = $urandom_range(0, MAX_VAL);
        foreach (pool[i]) pool[i] = sample_t'($urandom);
        for (int i = 0; i < count; i++) begin
            case (shape)
                0: x = $urandom_range(0, MAX_VAL);
                1: begin
                    if ($urandom_range(0, 3) == 0)
                        centre = $urandom_range(0, MAX_VAL);
                    x = centre + $urandom_range(0, 2 * int'(gap_model));
                end
                2: x = $urandom_range(0, 6) * int'(gap_model) + $urandom_range(0, 1);
                default: x = pool[$urandom_range(0, 2)];
            endcase
            if (x > MAX_VAL)
                x = MAX_VAL;
            send_sample(sample_t'(x), i == count - 1, 1'b0, none);
        end
    endtask

    function automatic bit field_ok(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Range sink: random stalls per word, with stretches of constant readiness.
    initial begin
        range_word_t want;
        bit          ok;
        int          stall;
        rng_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0)
                out_steady = !out_steady;
            stall = out_steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                rng_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rng_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rng_if.valid);
            if (pending_ranges.size() == 0) begin
                $display("%0t: range word low %0d high %0d with no range expected",
                         $time, rng_if.range_low, rng_if.range_high);
                mismatches++;
            end else begin
                want = pending_ranges.pop_front();
                ok = field_ok("range_low", want.lo, rng_if.range_low);
                ok &= field_ok("range_high", want.hi, rng_if.range_high);
                ok &= field_ok("sample_count", want.count, rng_if.sample_count);
                ok &= field_ok("last_range", want.fin, rng_if.last_range);
                ok &= field_ok("samples_dropped", want.dropped, rng_if.samples_dropped);
                if (!ok)
                    mismatches++;
            end
        end
    end

    // Ends the run if neither channel moves a word for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((smp_if.valid && smp_if.ready) || (rng_if.valid && rng_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int   random_items;
        int   set_no;
        int   count;
        int   pick;
        gap_t next_gap;
        i_rst_n            <= 1'b0;
        i_cfg_wr_en        <= 1'b0;
        i_cfg_wr_data      <= '0;
        smp_if.valid       <= 1'b0;
        smp_if.sample      <= '0;
        smp_if.last_sample <= 1'b0;
        in_steady  = 1'b0;
        set_spilled = 1'b0;
        gap_model  = ssrg_pkg::GAP_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_GAP)
                set_gap(script[i].value);
            else
                send_sample(script[i].value, script[i].fin, script[i].typed, script[i].want);
        end

        // Full and overflowing sets come first, the second one dropping its last sample.
        random_items = 0;
        set_no = 0;
        while (random_items < RANDOM_ITEMS) begin
            case (set_no)
                0: count = DEPTH;
                1: count = DEPTH + 1;
                2: count = DEPTH + 5;
                default: begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        count = DEPTH + $urandom_range(1, 6);
                    else if (pick == 1)
                        count = DEPTH;
                    else
                        count = $urandom_range(1, 10);
                end
            endcase
            send_random_set(count);
            random_items += count;
            set_no++;
            if ($urandom_range(0, 5) == 0)
                in_steady = !in_steady;
            if (set_no % 5 == 0) begin
                case ($urandom_range(0, 3))
                    0: next_gap = 12'd1;
                    1: next_gap = 12'd4095;
                    2: next_gap = gap_t'($urandom_range(1, 16));
                    default: next_gap = gap_t'($urandom_range(1, MAX_VAL));
                endcase
                set_gap(next_gap);
            end else if ($urandom_range(0, 7) == 0) begin
                drain_ranges();
            end
        end

        drain_ranges();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && pending_ranges.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
